FILE: rtl/hamming_nearest_item_search_assert.svh
// assertion macros for the nearest item search block
// expects clk and arst_n in the scope of the module that uses them
`ifndef HAMMING_NEAREST_ITEM_SEARCH_ASSERT_SVH
`define HAMMING_NEAREST_ITEM_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HNIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HNIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hnis_pkg.sv
// shared types and constants for the hamming nearest item search block
// no dependencies
`default_nettype none

package hnis_pkg;

	localparam int unsigned LABEL_W = 7;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned ACC_W   = 14;
	localparam int unsigned DIST_W  = 14;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [LABEL_W-1:0] entry_label;
		logic [INDEX_W-1:0] word_index;
		logic [DATA_W-1:0]  word_data;
		logic               last_word;
	} in_word_t;

	typedef struct packed {
		logic               found;
		logic [LABEL_W-1:0] best_label;
		logic [DIST_W-1:0]  best_distance;
	} out_word_t;

endpackage

`default_nettype wire

FILE: rtl/hamming_nearest_item_search.sv
// hamming nearest item search: item store, accumulator memory and sweep sequencer
// depends on hnis_pkg and hamming_nearest_item_search_assert.svh
`default_nettype none

// Associative item memory for binary hypervectors. A load word writes one word of one
// entry into the item store and marks the entry valid; a load word whose label or index
// lies outside the store is dropped. A query word sweeps the entries through one shared
// xor/popcount/add unit, one entry per cycle off the single read port of the item store
// and of the accumulator memory; a query word whose index lies past the vector and is
// not the last word is dropped without a sweep. On the last query word the nearest
// valid entry (lowest label on ties) is placed in the output register as soon as any
// earlier result has been taken, so a waiting result holds that word back until it is
// taken; the next word may be accepted while the new result waits. Accumulators are
// cleared by an active flag, so no clearing pass is needed after reset. Reading a word
// of a valid entry that was never loaded gives undefined data.
module hamming_nearest_item_search
	import hnis_pkg::*;
#(
	parameter int unsigned VECTOR_BITS = 10240,
	parameter int unsigned ENTRY_COUNT = 128,
	parameter int unsigned WORD_BITS   = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	localparam int unsigned WORDS = VECTOR_BITS / WORD_BITS;
	localparam int unsigned EW    = $clog2(ENTRY_COUNT);
	localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned DEPTH = ENTRY_COUNT * WORDS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned DW    = $clog2(VECTOR_BITS + 1);
	localparam int unsigned CW    = (DW > ACC_W) ? DW : ACC_W;
	localparam int unsigned PW    = $clog2(WORD_BITS + 1);
	localparam int unsigned LANES = (WORD_BITS + 7) / 8;
	localparam int unsigned SW    = ACC_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SWEEP,
		S_DRAIN,
		S_FINISH
	} state_t;

	function automatic logic [3:0] count8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, b[i]};
		end
		return n;
	endfunction

	state_t                 state_q;
	logic [ENTRY_COUNT-1:0] entry_valid_q;
	logic                   active_q;
	logic                   add_en_q;
	logic                   last_q;
	logic [EW-1:0]          idx_q;
	logic [AW-1:0]          addr_q;
	logic                   v_s1;
	logic                   v_s2;
	logic [DW-1:0]          best_d_q;
	logic [EW-1:0]          best_l_q;
	logic                   best_hit_q;
	logic                   out_valid_q;
	out_word_t              out_q;

	logic [AW-1:0]          ld_addr_q;
	logic [EW-1:0]          ld_entry_q;
	logic [WORD_BITS-1:0]   ld_data_q;
	logic [WORD_BITS-1:0]   q_data_q;

	logic [WORD_BITS-1:0]   store_mem [DEPTH];
	logic [ACC_W-1:0]       acc_mem [ENTRY_COUNT];

	logic [WORD_BITS-1:0]   store_rd_s1;
	logic [ACC_W-1:0]       acc_rd_s1;
	logic                   ent_v_s1;
	logic [EW-1:0]          idx_s1;

	logic [3:0]             cnt_s2 [LANES];
	logic [ACC_W-1:0]       base_s2;
	logic                   ent_v_s2;
	logic [EW-1:0]          idx_s2;

	logic                   accept;
	logic                   label_ok;
	logic                   widx_ok;
	logic [LANES*8-1:0]     diff_s1;
	logic [PW-1:0]          pop_s2;
	logic [SW-1:0]          sum_s2;
	logic [ACC_W-1:0]       new_acc_s2;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign label_ok  = 32'(in_data.entry_label) < ENTRY_COUNT;
	assign widx_ok   = 32'(in_data.word_index) < WORDS;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign diff_s1 = (LANES * 8)'(store_rd_s1 ^ q_data_q);

	always_comb begin
		pop_s2 = '0;
		for (int l = 0; l < LANES; l++) begin
			pop_s2 = pop_s2 + PW'(cnt_s2[l]);
		end
		sum_s2 = SW'(base_s2) + (add_en_q ? SW'(pop_s2) : SW'(0));
		if (!ent_v_s2) begin
			new_acc_s2 = '0;
		end else if (sum_s2 > SW'(ACC_MAX)) begin
			new_acc_s2 = ACC_MAX;
		end else begin
			new_acc_s2 = sum_s2[ACC_W-1:0];
		end
	end

	// item store and accumulator memory
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			store_mem[ld_addr_q] <= ld_data_q;
		end
		store_rd_s1 <= store_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (v_s2 && add_en_q) begin
			acc_mem[idx_s2] <= new_acc_s2;
		end
		acc_rd_s1 <= acc_mem[idx_q];
	end

	// payload capture and datapath stages
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_addr_q  <= AW'(AW'(in_data.entry_label) * AW'(WORDS) + AW'(in_data.word_index));
			ld_entry_q <= EW'(in_data.entry_label);
			ld_data_q  <= in_data.word_data[WORD_BITS-1:0];
			q_data_q   <= in_data.word_data[WORD_BITS-1:0];
		end
		ent_v_s1 <= entry_valid_q[idx_q];
		idx_s1   <= idx_q;
		for (int l = 0; l < LANES; l++) begin
			cnt_s2[l] <= count8(diff_s1[l*8 +: 8]);
		end
		base_s2  <= active_q ? acc_rd_s1 : '0;
		ent_v_s2 <= ent_v_s1;
		idx_s2   <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_valid_q <= '0;
			active_q      <= 1'b0;
			add_en_q      <= 1'b0;
			last_q        <= 1'b0;
			idx_q         <= '0;
			addr_q        <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			best_d_q      <= DW'(VECTOR_BITS);
			best_l_q      <= '0;
			best_hit_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			v_s1 <= (state_q == S_SWEEP);
			v_s2 <= v_s1;
			if (out_ready && !(state_q == S_FINISH && last_q)) begin
				out_valid_q <= 1'b0;
			end
			if (v_s2 && ent_v_s2 && (CW'(new_acc_s2) < CW'(best_d_q))) begin
				best_d_q   <= DW'(new_acc_s2);
				best_l_q   <= idx_s2;
				best_hit_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.req_type == REQ_LOAD) begin
							if (label_ok && widx_ok) begin
								state_q <= S_LOAD;
							end
						end else if (widx_ok || in_data.last_word) begin
							state_q    <= S_SWEEP;
							idx_q      <= '0;
							add_en_q   <= widx_ok;
							last_q     <= in_data.last_word;
							addr_q     <= widx_ok ? AW'(in_data.word_index) : '0;
							best_d_q   <= DW'(VECTOR_BITS);
							best_l_q   <= '0;
							best_hit_q <= 1'b0;
						end
					end
				end
				S_LOAD: begin
					entry_valid_q[ld_entry_q] <= 1'b1;
					state_q                   <= S_IDLE;
				end
				S_SWEEP: begin
					idx_q  <= idx_q + EW'(1);
					addr_q <= addr_q + AW'(WORDS);
					if (idx_q == EW'(ENTRY_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!last_q) begin
						active_q <= active_q || add_en_q;
						state_q  <= S_IDLE;
					end else if (!out_valid_q || out_ready) begin
						out_valid_q         <= 1'b1;
						out_q.found         <= best_hit_q;
						out_q.best_label    <= LABEL_W'(best_l_q);
						out_q.best_distance <= DIST_W'(best_d_q);
						active_q            <= 1'b0;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "hamming_nearest_item_search_assert.svh"

	`HNIS_ASSERT_NOW(a_accept_pipe_empty, accept, !v_s1 && !v_s2, "word accepted with sweep in flight")
	`HNIS_ASSERT_NOW(a_finish_drained, state_q == S_FINISH, !v_s1 && !v_s2, "result taken before drain")
	`HNIS_ASSERT_NOW(a_hit_below_len, best_hit_q, 32'(best_d_q) < VECTOR_BITS, "hit not below vector length")
	`HNIS_ASSERT_NEXT(a_result_from_last, !out_valid_q && !(state_q == S_FINISH && last_q), !out_valid_q, "result without last word")

endmodule

`default_nettype wire
